// ===== sv/lppw_pkg.sv =====
// Shared types, constants and helper functions for the LED ping-pong wipe block.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package lppw_pkg;

  localparam int PALETTE_SLOTS_DEF = 8;
  localparam int LED_MAX_DEF       = 256;

  localparam int FIFTIETHS   = 50;
  localparam int SPEED_W     = 7;
  localparam int SOFT_W      = 7;
  localparam int LEDS_W      = 9;
  localparam int COLORS_W    = 4;
  localparam int SPEED_MAX   = 127;
  localparam int SOFT_MAX    = 127;

  localparam int CH_W        = 8;
  localparam int RGB_W       = 24;
  localparam int D_W         = 13;
  localparam int DIV_STEPS   = 8;
  localparam int DIV_CNT_W   = 3;
  localparam int DSH_W       = D_W + DIV_STEPS - 1;
  localparam int PROD_W      = DSH_W + 1;
  localparam int COLOR_CNT_W = 5;
  localparam int SLOT_IDX_W  = 4;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFTNESS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT = 2'd3;

  localparam logic [SPEED_W-1:0]  SPEED_RST       = 7'd50;
  localparam logic [SOFT_W-1:0]   SOFTNESS_RST    = 7'd3;
  localparam logic [LEDS_W-1:0]   LED_COUNT_RST   = 9'd16;
  localparam logic [COLORS_W-1:0] COLOR_COUNT_RST = 4'd7;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_ADVANCE = 2'd1,
    KIND_WRITE   = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NUM,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_OUT,
    ST_ADV,
    ST_WRAP
  } state_t;

  typedef struct packed {
    logic capture;
    logic pal_write;
    logic pix_num;
    logic pix_mul;
    logic div_load;
    logic div_step;
    logic out_load;
    logic adv_move;
    logic adv_wrap;
  } ctl_cmd_t;

  function automatic logic [RGB_W-1:0] default_color(input logic [SLOT_IDX_W-1:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      4'd0:    c = 24'h00FF00;
      4'd1:    c = 24'h00FFFF;
      4'd2:    c = 24'h0000FF;
      4'd3:    c = 24'hFFFF00;
      4'd4:    c = 24'hFF0000;
      4'd5:    c = 24'hFF00FF;
      4'd6:    c = 24'hFFFFFF;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lppw_ctrl.sv =====
// Controller state machine for the LED ping-pong wipe block.
// Drives datapath commands and the handshakes; depends on lppw_pkg.
`default_nettype none

module lppw_ctrl
  import lppw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ctl_cmd_t             cmd
);

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] div_count, div_count_next;
  logic                 out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_count <= div_count_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    div_count_next = div_count;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (kind)
            KIND_PIXEL:   state_next = ST_NUM;
            KIND_ADVANCE: state_next = ST_ADV;
            KIND_WRITE:   cmd.pal_write = 1'b1;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_NUM: begin
        cmd.pix_num = 1'b1;
        state_next  = ST_MUL;
      end
      ST_MUL: begin
        cmd.pix_mul = 1'b1;
        state_next  = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load   = 1'b1;
        div_count_next = '0;
        state_next     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step   = 1'b1;
        div_count_next = div_count + DIV_CNT_W'(1);
        if (div_count == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_ADV: begin
        cmd.adv_move = 1'b1;
        state_next   = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.adv_wrap = 1'b1;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lppw_datapath.sv =====
// Datapath of the LED ping-pong wipe block: configuration, edge state, palette,
// blend multipliers and the per-channel restoring dividers. Depends on lppw_pkg.
`default_nettype none

module lppw_datapath
  import lppw_pkg::*;
#(
  parameter int PALETTE_SLOTS = PALETTE_SLOTS_DEF,
  parameter int LED_MAX       = LED_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  input  logic [7:0]            led_index,
  input  logic [2:0]            color_index,
  input  logic [RGB_W-1:0]      color_value,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [CH_W-1:0]       red,
  output logic [CH_W-1:0]       green,
  output logic [CH_W-1:0]       blue
);

  localparam int SLOT_W = $clog2(PALETTE_SLOTS);
  localparam int LED_W  = $clog2(LED_MAX + 1);
  localparam int POS_W  = $clog2(FIFTIETHS * (LED_MAX + 2 * SOFT_MAX) + SPEED_MAX + 1) + 1;

  function automatic logic [COLOR_CNT_W-1:0] mod_count(input logic [COLOR_CNT_W-1:0] val,
                                                        input logic [COLOR_CNT_W-1:0] m);
    logic [2*COLOR_CNT_W-1:0] r;
    logic [2*COLOR_CNT_W-1:0] mw;
    r  = (2*COLOR_CNT_W)'(val);
    mw = (2*COLOR_CNT_W)'(m);
    for (int i = COLOR_CNT_W - 1; i >= 0; i--) begin
      if (r >= (mw << i)) begin
        r = r - (mw << i);
      end
    end
    return r[COLOR_CNT_W-1:0];
  endfunction

  logic [SPEED_W-1:0]  speed;
  logic [SOFT_W-1:0]   softness;
  logic [LEDS_W-1:0]   led_count;
  logic [COLORS_W-1:0] color_count;

  logic [SOFT_W-1:0]      s_eff;
  logic [LED_W-1:0]       n_eff;
  logic [COLOR_CNT_W-1:0] eff_colors;
  logic [D_W-1:0]         d_val;
  logic signed [POS_W-1:0] d_s, hi_s, hi_m_s, spd_s, x_s;

  logic signed [POS_W-1:0] pos;
  logic                    rev;
  logic [SLOT_W-1:0]       ptr;

  logic [COLOR_CNT_W-1:0] ptr_inc;
  logic [SLOT_W-1:0]      nidx;
  logic [SLOT_W-1:0]      wr_idx;
  logic                   pal_wr_en;

  logic [RGB_W-1:0]         pal_mem [PALETTE_SLOTS];
  logic [PALETTE_SLOTS-1:0] pal_valid;
  logic [RGB_W-1:0]         cur_rd, nxt_rd;

  logic [7:0]        led_idx;
  logic [D_W-1:0]    num, num_c;
  logic [PROD_W-1:0] prod_n [3];
  logic [PROD_W-1:0] prod_c [3];
  logic [PROD_W-1:0] rem [3];
  logic [CH_W-1:0]   quo [3];
  logic [DSH_W-1:0]  dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed       <= SPEED_RST;
      softness    <= SOFTNESS_RST;
      led_count   <= LED_COUNT_RST;
      color_count <= COLOR_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SPEED:       speed       <= cfg_data[SPEED_W-1:0];
        CFG_SOFTNESS:    softness    <= cfg_data[SOFT_W-1:0];
        CFG_LED_COUNT:   led_count   <= cfg_data[LEDS_W-1:0];
        CFG_COLOR_COUNT: color_count <= cfg_data[COLORS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_eff = (softness == '0) ? SOFT_W'(1) : softness;
    if (32'(led_count) > LED_MAX) begin
      n_eff = LED_W'(LED_MAX);
    end else begin
      n_eff = LED_W'(led_count);
    end
    if (color_count == '0) begin
      eff_colors = COLOR_CNT_W'(1);
    end else if (32'(color_count) > PALETTE_SLOTS) begin
      eff_colors = COLOR_CNT_W'(PALETTE_SLOTS);
    end else begin
      eff_colors = COLOR_CNT_W'(color_count);
    end
    d_val  = D_W'(FIFTIETHS * int'(s_eff));
    d_s    = POS_W'(d_val);
    hi_s   = POS_W'(FIFTIETHS * (int'(n_eff) + int'(s_eff)));
    hi_m_s = POS_W'(FIFTIETHS * (int'(n_eff) + int'(s_eff) - 1));
    spd_s  = POS_W'(speed);
    x_s    = POS_W'(FIFTIETHS * int'(led_idx));
  end

  assign ptr_inc   = COLOR_CNT_W'(ptr) + COLOR_CNT_W'(1);
  assign nidx      = (ptr_inc < eff_colors) ? SLOT_W'(ptr_inc) : '0;
  assign wr_idx    = SLOT_W'(color_index);
  assign pal_wr_en = cmd.pal_write && (COLOR_CNT_W'(color_index) < eff_colors)
                     && (32'(color_index) < PALETTE_SLOTS);

  always_comb begin
    if (!rev) begin
      if (x_s < pos) begin
        num_c = d_val;
      end else if (x_s < pos + d_s) begin
        num_c = D_W'(pos + d_s - x_s);
      end else begin
        num_c = '0;
      end
    end else begin
      if (x_s >= pos) begin
        num_c = d_val;
      end else if (x_s >= pos - d_s) begin
        num_c = D_W'(x_s - (pos - d_s));
      end else begin
        num_c = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      rev <= 1'b0;
      ptr <= '0;
    end else if (cmd.adv_move) begin
      pos <= rev ? pos - spd_s : pos + spd_s;
    end else if (cmd.adv_wrap) begin
      if (pos >= hi_s || pos < -d_s) begin
        ptr <= SLOT_W'(mod_count(ptr_inc, eff_colors));
        rev <= !rev;
        pos <= rev ? -d_s : hi_m_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pal_wr_en) begin
      pal_mem[wr_idx] <= color_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
    end else if (pal_wr_en) begin
      pal_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      led_idx <= led_index;
    end
    if (cmd.pix_num) begin
      num    <= num_c;
      cur_rd <= pal_valid[ptr] ? pal_mem[ptr] : default_color(SLOT_IDX_W'(ptr));
      nxt_rd <= pal_valid[nidx] ? pal_mem[nidx] : default_color(SLOT_IDX_W'(nidx));
    end
    if (cmd.pix_mul) begin
      for (int c = 0; c < 3; c++) begin
        prod_n[c] <= PROD_W'(num) * PROD_W'(nxt_rd[CH_W*c +: CH_W]);
        prod_c[c] <= PROD_W'(d_val - num) * PROD_W'(cur_rd[CH_W*c +: CH_W]);
      end
    end
    if (cmd.div_load) begin
      for (int c = 0; c < 3; c++) begin
        rem[c] <= prod_n[c] + prod_c[c];
        quo[c] <= '0;
      end
      dsh <= DSH_W'(d_val) << (DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      for (int c = 0; c < 3; c++) begin
        if (rem[c] >= PROD_W'(dsh)) begin
          rem[c] <= rem[c] - PROD_W'(dsh);
          quo[c] <= {quo[c][CH_W-2:0], 1'b1};
        end else begin
          quo[c] <= {quo[c][CH_W-2:0], 1'b0};
        end
      end
      dsh <= dsh >> 1;
    end
    if (cmd.out_load) begin
      red   <= quo[0];
      green <= quo[1];
      blue  <= quo[2];
    end
  end

endmodule

`default_nettype wire

// ===== sv/led_ping_pong_wipe_core.sv =====
// Top level of the LED ping-pong wipe block: controller plus datapath.
// Depends on lppw_pkg, lppw_ctrl and lppw_datapath.
//
//   channel  signals                                   direction
//   in       in_valid/in_ready, kind, led_index,       into block
//            color_index, color_value
//   out      out_valid/out_ready, red, green, blue     out of block
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  into block
//
// A pixel request steps through the numerator, multiply, load, 8-step restoring divide
// (one divider per channel, sharing one divisor shift) and output states; the output
// state registers the result. Advances pass the move and wrap states; palette writes
// and unknown kinds end in idle. Reset restores the registers, the edge state and the
// default palette at once. A result held by a stalled output blocks the next input only
// once another pixel result is ready to replace it. Configuration writes are taken every cycle.
`default_nettype none

module led_ping_pong_wipe_core
  import lppw_pkg::*;
#(
  parameter int PALETTE_SLOTS = PALETTE_SLOTS_DEF,
  parameter int LED_MAX       = LED_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic [7:0]            led_index,
  input  logic [2:0]            color_index,
  input  logic [RGB_W-1:0]      color_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       red,
  output logic [CH_W-1:0]       green,
  output logic [CH_W-1:0]       blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  lppw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lppw_datapath #(
    .PALETTE_SLOTS (PALETTE_SLOTS),
    .LED_MAX       (LED_MAX)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .led_index   (led_index),
    .color_index (color_index),
    .color_value (color_value),
    .cfg_write   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

endmodule

`default_nettype wire

// ===== sv/lppw_checker.sv =====
// Port-level checker for the LED ping-pong wipe block, bound to the top level.
// Depends on lppw_pkg.
`default_nettype none

module lppw_checker
  import lppw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [CH_W-1:0]       red,
  input  logic [CH_W-1:0]       green,
  input  logic [CH_W-1:0]       blue
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("Result beat changed while stalled.");

  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_PIXEL || kind == KIND_ADVANCE) |=> !in_ready)
    else $error("Input taken again right after a pixel or advance beat.");

  a_write_no_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_WRITE |=> in_ready)
    else $error("Palette write stalled the input.");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind != KIND_PIXEL && !out_valid |=> !out_valid)
    else $error("Result appeared without a pixel request.");

endmodule

bind led_ping_pong_wipe_core lppw_checker u_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for led_ping_pong_wipe_core: directed and random pixel, advance and palette
// beats, with the expected colors worked out by a model of the wipe kept in this file.
// Depends on lppw_pkg and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lppw_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0]       k;
    logic [7:0]       led;
    logic [2:0]       slot;
    logic [RGB_W-1:0] value;
  } beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            kind = 2'd0;
  logic [7:0]            led_index = 8'd0;
  logic [2:0]            color_index = 3'd0;
  logic [RGB_W-1:0]      color_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CH_W-1:0]       red;
  logic [CH_W-1:0]       green;
  logic [CH_W-1:0]       blue;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SPEED;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [SPEED_W-1:0]  m_speed;
  logic [SOFT_W-1:0]   m_soft;
  logic [LEDS_W-1:0]   m_leds;
  logic [COLORS_W-1:0] m_colors;
  int                  front_pos;
  bit                  sweep_down;
  int                  pal_ptr;
  logic [RGB_W-1:0]    pal_copy [PALETTE_SLOTS_DEF];

  beat_t            pending [$];
  logic [RGB_W-1:0] pixel_exp [$];
  logic [RGB_W-1:0] want_rgb;
  beat_t            next_beat;
  int               errors = 0;
  bit               calm = 1'b0;
  bit               hold_go = 1'b0;
  bit               hold_done = 1'b0;
  int               gap_left = 0;
  int               stall_left = 0;
  int               hold_left = 0;

  led_ping_pong_wipe_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .led_index   (led_index),
    .color_index (color_index),
    .color_value (color_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic wipe_step(input logic [1:0] k, input logic [7:0] led,
                           input logic [2:0] slot, input logic [RGB_W-1:0] value);
    int ramp, colors, n, x, num, cur, nxt;
    logic [RGB_W-1:0] c0, c1, mix;
    ramp = FIFTIETHS * ((m_soft == 0) ? 1 : int'(m_soft));
    colors = (m_colors == 0) ? 1 :
             (m_colors > PALETTE_SLOTS_DEF) ? PALETTE_SLOTS_DEF : int'(m_colors);
    n = (m_leds > LED_MAX_DEF) ? LED_MAX_DEF : int'(m_leds);
    case (k)
      KIND_PIXEL: begin
        x = FIFTIETHS * int'(led);
        cur = pal_ptr % PALETTE_SLOTS_DEF;
        nxt = (cur + 1 < colors) ? cur + 1 : 0;
        if (!sweep_down) begin
          num = (x < front_pos) ? ramp :
                (x < front_pos + ramp) ? ramp - (x - front_pos) : 0;
        end else begin
          num = (x >= front_pos) ? ramp :
                (x >= front_pos - ramp) ? ramp - (front_pos - x) : 0;
        end
        c0 = pal_copy[cur];
        c1 = pal_copy[nxt];
        for (int sh = 0; sh < 3; sh++)
          mix[8*sh +: 8] = 8'((num * int'(c1[8*sh +: 8]) +
                               (ramp - num) * int'(c0[8*sh +: 8])) / ramp);
        pixel_exp.push_back(mix);
      end
      KIND_ADVANCE: begin
        front_pos = sweep_down ? front_pos - int'(m_speed) : front_pos + int'(m_speed);
        if (front_pos >= FIFTIETHS * n + ramp || front_pos < -ramp) begin
          pal_ptr = (pal_ptr + 1) % colors;
          sweep_down = !sweep_down;
          front_pos = sweep_down ? FIFTIETHS * (n - 1) + ramp : -ramp;
        end
      end
      KIND_WRITE: begin
        if (int'(slot) < colors) pal_copy[slot] = value;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_speed = SPEED_RST;
      m_soft = SOFTNESS_RST;
      m_leds = LED_COUNT_RST;
      m_colors = COLOR_COUNT_RST;
      front_pos = 0;
      sweep_down = 1'b0;
      pal_ptr = 0;
      pal_copy = '{24'h00FF00, 24'h00FFFF, 24'h0000FF, 24'hFFFF00,
                   24'hFF0000, 24'hFF00FF, 24'hFFFFFF, 24'h000000};
      pixel_exp.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_exp.size() == 0) begin
          $error("pixel beat with no request outstanding");
          errors++;
        end else begin
          want_rgb = pixel_exp.pop_front();
          if (red !== want_rgb[7:0]) begin
            $error("red: expected %0d, actual %0d", want_rgb[7:0], red);
            errors++;
          end
          if (green !== want_rgb[15:8]) begin
            $error("green: expected %0d, actual %0d", want_rgb[15:8], green);
            errors++;
          end
          if (blue !== want_rgb[23:16]) begin
            $error("blue: expected %0d, actual %0d", want_rgb[23:16], blue);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPEED:       m_speed = cfg_data[SPEED_W-1:0];
          CFG_SOFTNESS:    m_soft = cfg_data[SOFT_W-1:0];
          CFG_LED_COUNT:   m_leds = cfg_data[LEDS_W-1:0];
          CFG_COLOR_COUNT: m_colors = cfg_data[COLORS_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) wipe_step(kind, led_index, color_index, color_value);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_ready) begin
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (!calm && pending.size() != 0 && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap_left <= $urandom_range(0, 9);
    end else if (pending.size() != 0) begin
      next_beat = pending.pop_front();
      in_valid <= 1'b1;
      kind <= next_beat.k;
      led_index <= next_beat.led;
      color_index <= next_beat.slot;
      color_value <= next_beat.value;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      // Long hold-off so the pipeline backs up into the input side.
      out_ready <= 1'b0;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_beat(input logic [1:0] k, input logic [7:0] led,
                            input logic [2:0] slot, input logic [RGB_W-1:0] value);
    beat_t b;
    b = '{k, led, slot, value};
    pending.push_back(b);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || pixel_exp.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(input logic [8:0] s, input logic [8:0] so,
                            input logic [8:0] lc, input logic [8:0] cc);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  ids [4];
    vals = '{s, so, lc, cc};
    ids = '{CFG_SPEED, CFG_SOFTNESS, CFG_LED_COUNT, CFG_COLOR_COUNT};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= ids[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [8:0] pick_reg(input int lo, input int hi,
                                          input logic [8:0] rare_val);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return 9'($urandom_range(lo, hi));
    if (roll < 9) return rare_val;
    return 9'($urandom);
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    int roll, reach;
    roll = $urandom_range(0, 99);
    reach = int'(m_leds) + int'(m_soft) + 2;
    if (reach > 255) reach = 255;
    b.k = (roll < 50) ? KIND_PIXEL : (roll < 80) ? KIND_ADVANCE :
          (roll < 95) ? KIND_WRITE : KIND_UNKNOWN;
    b.led = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, reach)) : 8'($urandom);
    b.slot = 3'($urandom);
    b.value = 24'($urandom);
    return b;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    queue_beat(KIND_PIXEL, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd255, 3'd7, 24'hFFFFFF);
    queue_beat(KIND_PIXEL, 8'd1, 3'd0, 24'h0);
    queue_beat(KIND_ADVANCE, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd1, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd2, 3'd0, 24'h0);
    queue_beat(KIND_WRITE, 8'd0, 3'd7, 24'hFFFFFF);
    queue_beat(KIND_WRITE, 8'd0, 3'd0, 24'hFFFFFF);
    queue_beat(KIND_WRITE, 8'd0, 3'd1, 24'h000000);
    queue_beat(KIND_UNKNOWN, 8'd3, 3'd1, 24'hA5A5A5);
    queue_beat(KIND_PIXEL, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_ADVANCE, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd1, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd2, 3'd0, 24'h0);
    drain();

    write_regs(9'd127, 9'd0, 9'd0, 9'd0);
    queue_beat(KIND_PIXEL, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_ADVANCE, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_WRITE, 8'd0, 3'd1, 24'h123456);
    queue_beat(KIND_WRITE, 8'd0, 3'd0, 24'h5A3C96);
    queue_beat(KIND_ADVANCE, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd255, 3'd0, 24'h0);
    drain();

    write_regs(9'd0, 9'd127, 9'd511, 9'd15);
    for (int i = 0; i < PALETTE_SLOTS_DEF; i++)
      queue_beat(KIND_WRITE, 8'd0, 3'(i), 24'($urandom));
    queue_beat(KIND_PIXEL, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd128, 3'd0, 24'h0);
    queue_beat(KIND_ADVANCE, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd255, 3'd0, 24'h0);
    drain();

    // Step the palette pointer on, then shrink the color count below it.
    write_regs(9'd127, 9'd1, 9'd1, 9'd8);
    do begin
      queue_beat(KIND_ADVANCE, 8'd0, 3'd0, 24'h0);
      queue_beat(KIND_PIXEL, 8'd0, 3'd0, 24'h0);
      drain();
    end while (pal_ptr < 4);
    write_regs(9'd50, 9'd5, 9'd4, 9'd2);
    queue_beat(KIND_PIXEL, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd3, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd9, 3'd0, 24'h0);
    queue_beat(KIND_WRITE, 8'd0, 3'd2, 24'hFFFFFF);
    queue_beat(KIND_ADVANCE, 8'd0, 3'd0, 24'h0);
    queue_beat(KIND_PIXEL, 8'd2, 3'd0, 24'h0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) calm <= 1'b1;
      if (ph % 3 != 2)
        write_regs(pick_reg(0, 100, 9'd127),
                   pick_reg(1, 100, (ph % 2 != 0) ? 9'd0 : 9'd127),
                   pick_reg(1, 40, (ph % 2 != 0) ? 9'd0 : 9'd256),
                   pick_reg(1, 8, (ph % 2 != 0) ? 9'd0 : 9'd15));
      if (ph == 1) hold_go <= 1'b1;
      repeat (200) pending.push_back(rand_beat());
      drain();
    end

    if (errors == 0) $display("led_ping_pong_wipe_core regression: pass");
    else $display("led_ping_pong_wipe_core regression: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("led_ping_pong_wipe_core regression: fail");
    $finish;
  end

endmodule
